// ----- src/assert_macros.svh -----
// Assertion macros shared by the interpolator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tli_pkg.sv -----
// Shared types and constants of the table interpolator.
// Used by tli_front, tli_back, tli_div and the top level.
package tli_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int ENTRIES_W           = 5;
  localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 5'd2;
  localparam logic [ENTRIES_W-1:0] ENTRIES_MIN   = 5'd2;

  // Item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Range status codes
  localparam logic [1:0] ST_INSIDE = 2'd0;
  localparam logic [1:0] ST_BELOW  = 2'd1;
  localparam logic [1:0] ST_ABOVE  = 2'd2;

  typedef struct packed {
    logic               op;
    logic [3:0]         entry_index;
    logic signed [31:0] entry_x;
    logic signed [31:0] entry_y;
    logic signed [31:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_y;
    logic [1:0]         range_status;
  } out_item_t;

  // Classified item passed from the front to the back
  typedef struct packed {
    logic                 is_query;
    logic                 load_ok;
    logic [3:0]           entry_index;
    logic signed [31:0]   entry_x;
    logic signed [31:0]   entry_y;
    logic signed [31:0]   query_x;
    logic [ENTRIES_W-1:0] n;
  } work_t;

endpackage

// ----- src/tli_front.sv -----
// Front end: entry-count register, item classification and a two-entry work queue.
// Depends on tli_pkg.
module tli_front
  import tli_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             in_item,
  input  logic                 cfg_wr,
  input  logic [ENTRIES_W-1:0] cfg_data,
  output logic                 work_vld,
  input  logic                 work_take,
  output work_t                work
);

  logic [ENTRIES_W-1:0] table_entries;
  logic [ENTRIES_W-1:0] n_sat;
  work_t                entry;
  work_t                queue [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 push_ok;
  logic                 take_ok;

  // Entry count register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_entries <= ENTRIES_RESET;
    end else if (cfg_wr) begin
      table_entries <= cfg_data;
    end
  end

  // Clamp the entry count to 2..TABLE_DEPTH
  always_comb begin
    if (table_entries < ENTRIES_MIN) begin
      n_sat = ENTRIES_MIN;
    end else if (int'(table_entries) > TABLE_DEPTH) begin
      n_sat = ENTRIES_W'(TABLE_DEPTH);
    end else begin
      n_sat = table_entries;
    end
  end

  // Classify the incoming item
  always_comb begin
    entry.is_query    = (in_item.op == OP_QUERY);
    entry.load_ok     = (int'(in_item.entry_index) < TABLE_DEPTH);
    entry.entry_index = in_item.entry_index;
    entry.entry_x     = in_item.entry_x;
    entry.entry_y     = in_item.entry_y;
    entry.query_x     = in_item.query_x;
    entry.n           = n_sat;
  end

  assign full     = (count == 2'd2);
  assign work_vld = (count != 2'd0);
  assign push_ok  = push && !full;
  assign take_ok  = work_take && work_vld;
  assign work     = queue[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      queue[wr_ptr] <= entry;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_ok, take_ok})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/tli_div.sv -----
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 32-bit divisor.
// The high half of the dividend must be below the divisor. Depends on tli_pkg.
module tli_div
  import tli_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);

  localparam int QUO_W = 32;
  localparam int CNT_W = $clog2(QUO_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      rem_r;
  logic [31:0]      lo;
  logic [32:0]      trial;
  logic             ge;

  // One restoring step
  always_comb begin
    trial = {rem_r, lo[QUO_W-1]};
    ge    = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[63:32];
      lo    <= dividend[31:0];
    end else if (busy) begin
      rem_r <= ge ? 32'(trial - {1'b0, divisor}) : trial[31:0];
      lo    <= {lo[QUO_W-2:0], ge};
    end
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = lo;
  assign rem = rem_r;

endmodule

// ----- src/tli_back.sv -----
// Back end: breakpoint memory, table scan, interpolation and the result register.
// Depends on tli_pkg, tli_div and assert_macros.svh.
`include "assert_macros.svh"

module tli_back
  import tli_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      work_vld,
  input  work_t     work,
  output logic      work_take,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_RESOLVE = 3'd2;
  localparam logic [2:0] S_MUL     = 3'd3;
  localparam logic [2:0] S_DSTART  = 3'd4;
  localparam logic [2:0] S_DIV     = 3'd5;
  localparam logic [2:0] S_ROUND   = 3'd6;
  localparam logic [2:0] S_FINISH  = 3'd7;

  // Candidate segment kinds
  localparam logic [1:0] CAND_NONE   = 2'd0;
  localparam logic [1:0] CAND_EXACT  = 2'd1;
  localparam logic [1:0] CAND_INTERP = 2'd2;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] neg;
    neg = -v;
    return (v < 0) ? neg[31:0] : v[31:0];
  endfunction

  logic [2:0] state;

  // Breakpoint memory
  logic signed [31:0] mem_x [TABLE_DEPTH];
  logic signed [31:0] mem_y [TABLE_DEPTH];
  logic signed [31:0] mem_xq;
  logic signed [31:0] mem_yq;
  logic [ADDR_W-1:0]  rd_addr;
  logic               mem_we;

  // Scan registers
  logic signed [31:0]   q_x;
  logic [ENTRIES_W-1:0] n_r;
  logic [ENTRIES_W-1:0] rd_cnt;
  logic                 issuing;
  logic                 rd_vld;
  logic [ENTRIES_W-1:0] rd_idx;
  logic signed [31:0]   min_x, min_y, max_x, max_y;
  logic signed [31:0]   prev_x, prev_y;
  logic [1:0]           cand_kind;
  logic signed [31:0]   cand_y;
  logic signed [31:0]   seg_x0, seg_y0, seg_x1, seg_y1;

  // Arithmetic registers
  logic [31:0]        mag_a, mag_b, mag_d;
  logic               neg_t;
  logic signed [31:0] base_y;
  logic [63:0]        prod;
  logic [32:0]        t_r;
  logic               div_start;
  logic               div_done;
  logic [31:0]        div_quo;
  logic [31:0]        div_rem;
  logic signed [33:0] sum;

  // Pending and delivered result
  logic signed [31:0] pend_y;
  logic [1:0]         pend_st;
  logic               out_vld;

  assign work_take = (state == S_IDLE) && work_vld;
  assign mem_we    = work_take && !work.is_query && work.load_ok;
  assign rd_addr   = ADDR_W'(rd_cnt);
  assign div_start = (state == S_DSTART);
  assign empty     = !out_vld;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[ADDR_W'(work.entry_index)] <= work.entry_x;
      mem_y[ADDR_W'(work.entry_index)] <= work.entry_y;
    end
    mem_xq <= mem_x[rd_addr];
    mem_yq <= mem_y[rd_addr];
  end

  tli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (mag_d),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Final add with saturation input
  always_comb begin
    if (neg_t) begin
      sum = {{2{base_y[31]}}, base_y} - $signed({1'b0, t_r});
    end else begin
      sum = {{2{base_y[31]}}, base_y} + $signed({1'b0, t_r});
    end
  end

  // Payload registers of the scan and arithmetic path
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (work_take && work.is_query) begin
          q_x       <= work.query_x;
          n_r       <= work.n;
          cand_kind <= CAND_NONE;
        end
      end
      S_SCAN: begin
        if (rd_vld) begin
          prev_x <= mem_xq;
          prev_y <= mem_yq;
          if (rd_idx == '0) begin
            min_x <= mem_xq;
            min_y <= mem_yq;
            max_x <= mem_xq;
            max_y <= mem_yq;
          end else begin
            if (mem_xq <= min_x) begin
              min_x <= mem_xq;
              min_y <= mem_yq;
            end
            if (mem_xq >= max_x) begin
              max_x <= mem_xq;
              max_y <= mem_yq;
            end
            // Segment between previous and current entry; the last candidate wins
            if (q_x == mem_xq) begin
              cand_kind <= CAND_EXACT;
              cand_y    <= mem_yq;
            end else if (q_x == prev_x) begin
              cand_kind <= CAND_EXACT;
              cand_y    <= prev_y;
            end else if ((q_x > prev_x && q_x < mem_xq) ||
                         (q_x < prev_x && q_x > mem_xq)) begin
              cand_kind <= CAND_INTERP;
              seg_x0    <= prev_x;
              seg_y0    <= prev_y;
              seg_x1    <= mem_xq;
              seg_y1    <= mem_yq;
            end
          end
        end
      end
      S_RESOLVE: begin
        if (q_x < min_x) begin
          pend_y  <= min_y;
          pend_st <= ST_BELOW;
        end else if (q_x > max_x) begin
          pend_y  <= max_y;
          pend_st <= ST_ABOVE;
        end else begin
          pend_st <= ST_INSIDE;
          case (cand_kind)
            CAND_EXACT:  pend_y <= cand_y;
            CAND_INTERP: pend_y <= seg_y0;
            default:     pend_y <= '0;
          endcase
          mag_a  <= mag33({q_x[31], q_x} - {seg_x0[31], seg_x0});
          mag_b  <= mag33({seg_y1[31], seg_y1} - {seg_y0[31], seg_y0});
          mag_d  <= mag33({seg_x1[31], seg_x1} - {seg_x0[31], seg_x0});
          neg_t  <= (seg_y1 < seg_y0);
          base_y <= seg_y0;
        end
      end
      S_MUL: begin
        prod <= mag_a * mag_b;
      end
      S_DIV: begin
        // Round to nearest, ties away from zero
        if (div_done) begin
          t_r <= {1'b0, div_quo} + 33'(({div_rem, 1'b0} >= {1'b0, mag_d}) ? 1 : 0);
        end
      end
      S_ROUND: begin
        if (sum > 34'sd2147483647) begin
          pend_y <= 32'sh7FFFFFFF;
        end else if (sum < -34'sd2147483648) begin
          pend_y <= 32'sh80000000;
        end else begin
          pend_y <= sum[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Result register, written when the sequencer finishes a query
  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && !out_vld) begin
      out_item.result_y     <= pend_y;
      out_item.range_status <= pend_st;
    end
  end

  // Sequencer and read issue control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      issuing <= 1'b0;
      rd_vld  <= 1'b0;
      rd_cnt  <= '0;
      rd_idx  <= '0;
      out_vld <= 1'b0;
    end else begin
      if (pop && out_vld) begin
        out_vld <= 1'b0;
      end
      rd_vld <= issuing;
      rd_idx <= rd_cnt;
      if (issuing) begin
        rd_cnt <= rd_cnt + 1'b1;
        if (rd_cnt == n_r - 1'b1) begin
          issuing <= 1'b0;
        end
      end
      case (state)
        S_IDLE: begin
          if (work_take && work.is_query) begin
            rd_cnt  <= '0;
            issuing <= 1'b1;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_vld && (rd_idx == n_r - 1'b1)) begin
            state <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          if (q_x >= min_x && q_x <= max_x && cand_kind == CAND_INTERP) begin
            state <= S_MUL;
          end else begin
            state <= S_FINISH;
          end
        end
        S_MUL:    state <= S_DSTART;
        S_DSTART: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: state <= S_FINISH;
        S_FINISH: begin
          if (!out_vld) begin
            out_vld <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_take_idle, clk, rst, work_take, state == S_IDLE, "work taken while busy")
  `ASSERT_IMPLIES(a_read_in_scan, clk, rst, rd_vld, state == S_SCAN, "read data outside scan")
  `ASSERT_IMPLIES(a_div_in_div, clk, rst, div_done, state == S_DIV, "divider done unexpected")
  `ASSERT_NEXT(a_finish_fills, clk, rst, state == S_FINISH && !out_vld, out_vld, "result lost")

endmodule

// ----- src/table_linear_interpolator_top.sv -----
// Piecewise linear table interpolator, top level.
// Input channel: push/full with in_item; an item is taken when push is high and full low.
// Result channel: empty/pop with out_item; the oldest result is shown while empty is low
// and leaves when pop is high.
// Config: cfg_wr/cfg_data write the number of breakpoints in use (clamped to 2..TABLE_DEPTH).
// A load item (op 0) writes one breakpoint pair as the back end takes it and gives no
// result. A query item (op 1) gives one result.
// Queries: the scan reads the table through one memory read port, one entry per
// cycle; a clamped or exact query then finishes, and an interpolated one goes on through
// one multiply, a 32-step serial divide and rounding. The back end takes the next item
// once the result is in the output register, and an item reaches the back end from the
// work queue, which registers it on push.
// Queries are handled one at a time; a two-entry work queue takes items while the
// back end works, so up to two items wait behind the running one.
// Reset empties the queue and the result register and sets the entry count to 2; table contents
// are undefined until loaded. When the receiver stalls, the finished result stays in the
// output register and the next query holds in the back end until it is popped.
// Depends on tli_pkg, tli_front, tli_back.
module table_linear_interpolator_top
  import tli_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             in_item,
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            out_item,
  input  logic                 cfg_wr,
  input  logic [ENTRIES_W-1:0] cfg_data
);

  logic  work_vld;
  logic  work_take;
  work_t work;

  tli_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cfg_wr    (cfg_wr),
    .cfg_data  (cfg_data),
    .work_vld  (work_vld),
    .work_take (work_take),
    .work      (work)
  );

  tli_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .work_vld  (work_vld),
    .work      (work),
    .work_take (work_take),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

// ----- test/tb_table_linear_interpolator_top.sv -----
// Self-checking testbench for table_linear_interpolator_top: loads breakpoint tables,
// sends interpolation queries and checks every result against an in-bench predictor.
// Depends on tli_pkg and table_linear_interpolator_top.
module tb_table_linear_interpolator_top;
  import tli_pkg::*;

  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_ITEMS    = 83;

  logic clk;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item;
  logic cfg_wr = 1'b0;
  logic [ENTRIES_W-1:0] cfg_data = '0;

  // Predictor copy of the block's state
  logic signed [31:0] knot_x [DEFAULT_TABLE_DEPTH];
  logic signed [31:0] knot_y [DEFAULT_TABLE_DEPTH];
  logic [ENTRIES_W-1:0] entries_reg = ENTRIES_RESET;

  // Stimulus side: items waiting for the driver, and the x values as they will be loaded
  in_item_t pending_items[$];
  logic signed [31:0] queued_x [DEFAULT_TABLE_DEPTH];
  int queued_n = 2;

  out_item_t expected_results[$];
  out_item_t next_expected;
  int mismatch_count = 0;
  int results_checked = 0;
  int idle_cycles = 0;

  int send_gap = 0;
  bit send_burst = 1'b0;
  int recv_gap = 0;
  int hold_left = 0;
  bit recv_burst = 1'b0;
  bit long_hold_done = 1'b0;

  table_linear_interpolator_top dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_wr   (cfg_wr),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Entry count as the block applies it
  function automatic int active_entries(logic [ENTRIES_W-1:0] v);
    if (v < ENTRIES_MIN) return int'(ENTRIES_MIN);
    if (int'(v) > DEFAULT_TABLE_DEPTH) return DEFAULT_TABLE_DEPTH;
    return int'(v);
  endfunction

  // Clamp or interpolate a query against the current table
  function automatic out_item_t interpolate_at(logic signed [31:0] q);
    int n, lo_i, hi_i, i;
    longint qv, x0, x1, y0, y1, res, t;
    longint unsigned a, b, d, prod, quo, rem;
    out_item_t r;
    n = active_entries(entries_reg);
    lo_i = 0;
    hi_i = 0;
    for (i = 1; i < n; i++) begin
      // ties go to the highest index
      if (knot_x[i] <= knot_x[lo_i]) lo_i = i;
      if (knot_x[i] >= knot_x[hi_i]) hi_i = i;
    end
    qv = q;
    res = 0;
    r.range_status = ST_INSIDE;
    if (q < knot_x[lo_i]) begin
      res = knot_y[lo_i];
      r.range_status = ST_BELOW;
    end else if (q > knot_x[hi_i]) begin
      res = knot_y[hi_i];
      r.range_status = ST_ABOVE;
    end else begin
      // last bracketing segment wins; exact hits take the endpoint y
      for (i = 0; i + 1 < n; i++) begin
        x0 = knot_x[i];
        x1 = knot_x[i + 1];
        y0 = knot_y[i];
        y1 = knot_y[i + 1];
        if (qv == x1) begin
          res = y1;
        end else if (qv == x0) begin
          res = y0;
        end else if ((qv > x0 && qv < x1) || (qv < x0 && qv > x1)) begin
          a = (qv > x0) ? qv - x0 : x0 - qv;
          b = (y1 > y0) ? y1 - y0 : y0 - y1;
          d = (x1 > x0) ? x1 - x0 : x0 - x1;
          prod = a * b;
          quo = prod / d;
          rem = prod % d;
          // round half away from zero
          if (rem * 2 >= d) quo++;
          t = (y1 < y0) ? -longint'(quo) : longint'(quo);
          res = y0 + t;
          if (res > 64'sd2147483647) res = 64'sd2147483647;
          if (res < -64'sd2147483648) res = -64'sd2147483648;
        end
      end
    end
    r.result_y = res[31:0];
    return r;
  endfunction

  function automatic void apply_item(in_item_t it);
    if (it.op == OP_LOAD) begin
      knot_x[it.entry_index] = it.entry_x;
      knot_y[it.entry_index] = it.entry_y;
    end else begin
      expected_results.push_back(interpolate_at(it.query_x));
    end
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return (int'($urandom_range(0, 10)) - 5) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_load(int idx, logic signed [31:0] x, logic signed [31:0] y);
    in_item_t it;
    it.op = OP_LOAD;
    it.entry_index = idx[3:0];
    it.entry_x = x;
    it.entry_y = y;
    it.query_x = $urandom;
    queued_x[idx] = x;
    pending_items.push_back(it);
  endtask

  task automatic add_query(logic signed [31:0] q);
    in_item_t it;
    it.op = OP_QUERY;
    it.entry_index = 4'($urandom);
    it.entry_x = $urandom;
    it.entry_y = $urandom;
    it.query_x = q;
    pending_items.push_back(it);
  endtask

  // Wait for all items sent and answered, then let a trailing load retire
  task automatic wait_idle();
    while (pending_items.size() != 0 || push || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_entries(logic [ENTRIES_W-1:0] v);
    wait_idle();
    cfg_wr <= 1'b1;
    cfg_data <= v;
    entries_reg = v;
    queued_n = active_entries(v);
    @(posedge clk);
    cfg_wr <= 1'b0;
  endtask

  // One phase: rebuild the entries in use, then mostly queries with some stray loads
  task automatic run_phase(int style, int count);
    int i, k, sel;
    longint base, stride, lo, hi, xv;
    base = longint'($signed($urandom)) >>> 2;
    for (i = 0; i < queued_n; i++) begin
      stride = longint'($urandom_range(1, 1 << $urandom_range(0, 24)));
      case (style)
        0: begin
          base += stride;
          xv = base;
        end
        1: begin
          base -= stride;
          xv = base;
        end
        2: xv = (int'($urandom_range(0, 10)) - 5) <<< 16;
        default: xv = pick_value();
      endcase
      add_load(i, xv[31:0], pick_value());
    end
    for (i = queued_n; i < count; i++) begin
      sel = $urandom_range(0, 99);
      k = $urandom_range(0, queued_n - 2);
      if (sel < 20) begin
        add_load(($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : k,
                 pick_value(), pick_value());
      end else if (sel < 50) begin
        // somewhere inside segment k
        lo = queued_x[k];
        hi = queued_x[k + 1];
        if (lo > hi) begin
          xv = lo;
          lo = hi;
          hi = xv;
        end
        xv = lo + longint'($urandom) % (hi - lo + 1);
        add_query(xv[31:0]);
      end else if (sel < 70) begin
        add_query(queued_x[k + $urandom_range(0, 1)]);
      end else if (sel < 80) begin
        add_query(queued_x[k] + (($urandom_range(0, 1) == 0) ? 1 : -1));
      end else begin
        add_query(pick_value());
      end
    end
  endtask

  // Sender: one item at a time from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
    end else if (!(push && full)) begin
      if (push) begin
        apply_item(in_item);
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 14);
      end
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_item <= pending_items.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: check each result, then stall for a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result: result_y %h range_status %0d",
                   $time, out_item.result_y, out_item.range_status);
        end else begin
          next_expected = expected_results.pop_front();
          if (out_item.result_y !== next_expected.result_y) begin
            mismatch_count++;
            $display("%0t: result_y mismatch: expected %h actual %h",
                     $time, next_expected.result_y, out_item.result_y);
          end
          if (out_item.range_status !== next_expected.range_status) begin
            mismatch_count++;
            $display("%0t: range_status mismatch: expected %0d actual %0d",
                     $time, next_expected.range_status, out_item.range_status);
          end
        end
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, 14);
      end
      // one long hold mid-phase so the input side backs up
      if (!long_hold_done && results_checked > 100 && pending_items.size() > 30) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int ph;
    logic [ENTRIES_W-1:0] cfg_v;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed, two entries in use after reset
    add_load(0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    add_load(1, 32'sh7FFF_FFFF, 32'sh8000_0000);
    add_query(32'sh8000_0000);   // exact hit, low end
    add_query(32'sh7FFF_FFFF);   // exact hit, high end
    add_query(32'sh0000_0000);   // full-range interior
    add_query(-32'sd1);
    add_load(0, 32'sd0, 32'sd0);
    add_load(1, 32'sd2, 32'sd1);
    add_query(32'sd1);           // half-way tie rounds up
    add_load(1, 32'sd2, -32'sd1);
    add_query(32'sd1);           // tie rounds away from zero, downward slope
    add_query(-32'sd5);          // below
    add_query(32'sd3);           // above
    add_load(0, 32'sh0001_0000, 32'sh0010_0000);
    add_load(1, 32'sh0001_0000, 32'sh0020_0000);
    add_query(32'sh0001_0000);   // both endpoints hit, later one wins
    add_query(32'sh0000_0000);   // min tie
    add_query(32'sh0002_0000);   // max tie
    add_load(15, 32'sh7FFF_FFFF, -32'sd1);
    add_load(0, 32'sh7FFF_0000, 32'sh8000_0000);
    add_load(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    add_query(32'sh7FFF_8000);   // steep segment
    add_load(0, 32'sh0003_0000, 32'sd10);
    add_load(1, 32'sh0001_0000, 32'sd30);
    add_query(32'sh0002_0000);   // descending x

    // Random phases over a range of entry counts, extremes included
    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: cfg_v = 5'd31;
        1: cfg_v = 5'd0;
        2: cfg_v = 5'd16;
        3: cfg_v = 5'd1;
        4: cfg_v = 5'd7;
        5: cfg_v = 5'd2;
        6: cfg_v = 5'd17;
        7: cfg_v = 5'd12;
        8: cfg_v = 5'd3;
        default: cfg_v = ENTRIES_W'($urandom_range(0, 31));
      endcase
      write_entries(cfg_v);
      run_phase(ph % 4, PHASE_ITEMS);
    end

    wait_idle();
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
